// File: rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock, held off while reset is active.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked only while a result is waiting on the output ports.
`define ASSERT_OUT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (!out_empty |-> (cond))) \
    else $error(msg);

`endif

// File: rtl/pce_pkg.sv
// Package with types, constants and register codes of the field evaluator.
`timescale 1ns / 1ps
package pce_pkg;

  localparam int CHARGE_MAX     = 2;
  localparam int CHARGE_COUNT_D = 2;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [15:0] RST_A_X    = 16'd32768;
  localparam logic [15:0] RST_A_Y    = 16'd26214;
  localparam logic [15:0] RST_A_Q    = 16'd768;
  localparam logic [15:0] RST_B_X    = 16'd32768;
  localparam logic [15:0] RST_B_Y    = 16'd39322;
  localparam logic [15:0] RST_B_Q    = 16'hF600;
  localparam logic [15:0] RST_RADIUS = 16'd655;

  // Largest magnitude a single charge term may contribute.
  localparam logic [40:0] TERM_CAP = 41'h100_0000_0000;

  typedef enum logic [2:0] {
    REG_A_X    = 3'd0,
    REG_A_Y    = 3'd1,
    REG_A_Q    = 3'd2,
    REG_B_X    = 3'd3,
    REG_B_Y    = 3'd4,
    REG_B_Q    = 3'd5,
    REG_RADIUS = 3'd6
  } cfg_reg_t;

  // Classified offset of the probe from one charge.
  typedef struct packed {
    logic [15:0] ad_x;
    logic [15:0] ad_y;
    logic        neg_x;
    logic        neg_y;
    logic        skip;
    logic [15:0] aq;
    logic [32:0] d2;
  } chg_t;

endpackage

// File: rtl/pce_front.sv
// Front end: forms per-charge offsets, squared distance and the skip decision.
`timescale 1ns / 1ps
module pce_front
  import pce_pkg::*;
#(
  parameter int CHARGE_COUNT = CHARGE_COUNT_D
) (
  input  logic [15:0]                      probe_x,
  input  logic [15:0]                      probe_y,
  input  logic [CHARGE_MAX-1:0][15:0]      cx,
  input  logic [CHARGE_MAX-1:0][15:0]      cy,
  input  logic [CHARGE_MAX-1:0][15:0]      cq,
  input  logic [15:0]                      radius,
  output chg_t [CHARGE_COUNT-1:0]          item
);

  logic [31:0] r2;

  assign r2 = radius * radius;

  always_comb begin
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [31:0]        sqx;
    logic [31:0]        sqy;
    for (int k = 0; k < CHARGE_COUNT; k++) begin
      dx = $signed({1'b0, probe_x}) - $signed({1'b0, cx[k]});
      dy = $signed({1'b0, probe_y}) - $signed({1'b0, cy[k]});
      item[k].ad_x  = dx[16] ? 16'(-dx) : dx[15:0];
      item[k].ad_y  = dy[16] ? 16'(-dy) : dy[15:0];
      item[k].neg_x = dx[16] ^ cq[k][15];
      item[k].neg_y = dy[16] ^ cq[k][15];
      item[k].aq    = cq[k][15] ? 16'(-cq[k]) : cq[k];
      sqx = item[k].ad_x * item[k].ad_x;
      sqy = item[k].ad_y * item[k].ad_y;
      item[k].d2    = {1'b0, sqx} + {1'b0, sqy};
      item[k].skip  = (item[k].d2 == 33'd0) || (item[k].d2 < {1'b0, r2});
    end
  end

endmodule

// File: rtl/pce_queue.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module pce_queue
  import pce_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_r];

  always_comb begin
    wr_nxt  = (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_nxt;
      end
      if (do_pop) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/pce_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module pce_sqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [IN_W-1:0]   rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_v,
  output logic [IN_W/2-1:0] root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int R = IN_W / 2;

  logic [IN_W-1:0]   rad_r  [R];
  logic [R:0]        rem_r  [R];
  logic [R-1:0]      root_r [R];
  logic [SIDE_W-1:0] side_r [R];
  logic [R-1:0]      v_r;

  logic [IN_W-1:0]   rad_nxt  [R];
  logic [R:0]        rem_nxt  [R];
  logic [R-1:0]      root_nxt [R];

  always_comb begin
    logic [IN_W-1:0] ra;
    logic [R:0]      re;
    logic [R-1:0]    ro;
    logic [R+2:0]    sh;
    logic [R+2:0]    trial;
    logic            ge;
    for (int i = 0; i < R; i++) begin
      if (i == 0) begin
        ra = rad;
        re = '0;
        ro = '0;
      end else begin
        ra = rad_r[i-1];
        re = rem_r[i-1];
        ro = root_r[i-1];
      end
      sh          = {re, ra[IN_W-1 -: 2]};
      trial       = {1'b0, ro, 2'b01};
      ge          = (sh >= trial);
      rem_nxt[i]  = ge ? (R+1)'(sh - trial) : sh[R:0];
      root_nxt[i] = {ro[R-2:0], ge};
      rad_nxt[i]  = {ra[IN_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < R; i++) begin
        rad_r[i]  <= rad_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        side_r[i] <= (i == 0) ? side_in : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[R-2:0], in_v};
    end
  end

  assign out_v    = v_r[R-1];
  assign root     = root_r[R-1];
  assign side_out = side_r[R-1];

endmodule

// File: rtl/pce_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pce_div #(
  parameter int NUM_W  = 52,
  parameter int DEN_W  = 33,
  parameter int Q_W    = 52,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_v,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  // The quotient must fit in Q_W bits, so the bits above them start as the remainder.
  logic [DEN_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    sh_r   [Q_W];
  logic [DEN_W-1:0]  den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic [Q_W-1:0]    v_r;

  logic [DEN_W-1:0]  rem_nxt [Q_W];
  logic [Q_W-1:0]    sh_nxt  [Q_W];

  always_comb begin
    logic [DEN_W-1:0] re;
    logic [Q_W-1:0]   sh;
    logic [DEN_W-1:0] dn;
    logic [DEN_W:0]   t;
    logic             ge;
    for (int i = 0; i < Q_W; i++) begin
      if (i == 0) begin
        re = DEN_W'(num >> Q_W);
        sh = num[Q_W-1:0];
        dn = den;
      end else begin
        re = rem_r[i-1];
        sh = sh_r[i-1];
        dn = den_r[i-1];
      end
      t          = {re, sh[Q_W-1]};
      ge         = (t >= {1'b0, dn});
      rem_nxt[i] = ge ? DEN_W'(t - {1'b0, dn}) : t[DEN_W-1:0];
      sh_nxt[i]  = {sh[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Q_W; i++) begin
        rem_r[i]  <= rem_nxt[i];
        sh_r[i]   <= sh_nxt[i];
        den_r[i]  <= (i == 0) ? den : den_r[(i == 0) ? 0 : i-1];
        side_r[i] <= (i == 0) ? side_in : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[Q_W-2:0], in_v};
    end
  end

  assign out_v    = v_r[Q_W-1];
  assign quo      = sh_r[Q_W-1];
  assign side_out = side_r[Q_W-1];

endmodule

// File: rtl/pce_back.sv
// Back end: charge terms, summation, saturation, length and direction.
`timescale 1ns / 1ps
module pce_back
  import pce_pkg::*;
#(
  parameter int CHARGE_COUNT = CHARGE_COUNT_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  chg_t [CHARGE_COUNT-1:0]  item,
  input  logic                     item_v,
  output logic                     item_pop,
  output logic signed [31:0]       field_x,
  output logic signed [31:0]       field_y,
  output logic [30:0]              field_length,
  output logic signed [15:0]       unit_x,
  output logic signed [15:0]       unit_y,
  output logic                     clipped,
  output logic                     res_empty,
  input  logic                     res_pop
);

  logic adv;
  logic ov_r;

  // The whole pipeline moves together; it halts only while a result waits unread.
  assign adv      = !ov_r || res_pop;
  assign item_pop = adv && item_v;

  // Returns {clip, signed term} for one component of one charge.
  function automatic logic [42:0] term_f(input logic [57:0] ph, input logic [57:0] pl,
                                         input logic neg, input logic skip);
    logic [83:0] full;
    logic [53:0] mag;
    logic [40:0] capd;
    logic        clp;
    logic [41:0] t;
    full = {ph, 26'b0} + {26'b0, pl};
    mag  = full[83:30];
    clp  = (mag > 54'(TERM_CAP));
    capd = clp ? TERM_CAP : mag[40:0];
    t    = neg ? -{1'b0, capd} : {1'b0, capd};
    if (skip) begin
      t   = '0;
      clp = 1'b0;
    end
    return {clp, t};
  endfunction

  logic signed [41:0]      term_x_r [CHARGE_COUNT];
  logic signed [41:0]      term_y_r [CHARGE_COUNT];
  logic [CHARGE_COUNT-1:0] tclip_r;
  logic [CHARGE_COUNT-1:0] tv_r;

  for (genvar k = 0; k < CHARGE_COUNT; k++) begin : g_lane
    logic [31:0] s_w;
    chg_t        sq_side;
    logic        sq_v;
    logic [51:0] m_w, ux_w, uy_w;
    logic        skip_w, nx_w, ny_w;
    logic        mv, uxv, uyv;
    logic [57:0] plx_r, phx_r, ply_r, phy_r;
    logic        nx_r, ny_r, skip_r, mv_r;
    logic [42:0] tx, ty;

    pce_sqrt #(.IN_W(64), .SIDE_W($bits(chg_t))) u_dist (
      .clk, .rst_n, .en(adv), .in_v(item_v),
      .rad({1'b0, item[k].d2, 30'b0}), .side_in(item[k]),
      .out_v(sq_v), .root(s_w), .side_out(sq_side)
    );

    pce_div #(.NUM_W(52), .DEN_W(33), .Q_W(52), .SIDE_W(1)) u_mag (
      .clk, .rst_n, .en(adv), .in_v(sq_v),
      .num({sq_side.aq, 36'b0}), .den(sq_side.d2), .side_in(sq_side.skip),
      .out_v(mv), .quo(m_w), .side_out(skip_w)
    );

    pce_div #(.NUM_W(61), .DEN_W(32), .Q_W(52), .SIDE_W(1)) u_dirx (
      .clk, .rst_n, .en(adv), .in_v(sq_v),
      .num({sq_side.ad_x, 45'b0}), .den(s_w), .side_in(sq_side.neg_x),
      .out_v(uxv), .quo(ux_w), .side_out(nx_w)
    );

    pce_div #(.NUM_W(61), .DEN_W(32), .Q_W(52), .SIDE_W(1)) u_diry (
      .clk, .rst_n, .en(adv), .in_v(sq_v),
      .num({sq_side.ad_y, 45'b0}), .den(s_w), .side_in(sq_side.neg_y),
      .out_v(uyv), .quo(uy_w), .side_out(ny_w)
    );

    // Unit components stay below 2^32, so the low 32 bits carry them whole.
    always_ff @(posedge clk) begin
      if (adv) begin
        plx_r  <= m_w[25:0] * ux_w[31:0];
        phx_r  <= m_w[51:26] * ux_w[31:0];
        ply_r  <= m_w[25:0] * uy_w[31:0];
        phy_r  <= m_w[51:26] * uy_w[31:0];
        nx_r   <= nx_w;
        ny_r   <= ny_w;
        skip_r <= skip_w;
      end
    end

    assign tx = term_f(phx_r, plx_r, nx_r, skip_r);
    assign ty = term_f(phy_r, ply_r, ny_r, skip_r);

    always_ff @(posedge clk) begin
      if (adv) begin
        term_x_r[k] <= $signed(tx[41:0]);
        term_y_r[k] <= $signed(ty[41:0]);
        tclip_r[k]  <= tx[42] | ty[42];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r    <= 1'b0;
        tv_r[k] <= 1'b0;
      end else if (adv) begin
        mv_r    <= mv & uxv & uyv;
        tv_r[k] <= mv_r;
      end
    end
  end

  // Sum of terms and saturation to the 32-bit field range.
  logic signed [42:0] acc_x, acc_y;
  logic signed [31:0] sx, sy;
  logic               sclip;

  always_comb begin
    acc_x = '0;
    acc_y = '0;
    for (int k = 0; k < CHARGE_COUNT; k++) begin
      acc_x = acc_x + 43'(term_x_r[k]);
      acc_y = acc_y + 43'(term_y_r[k]);
    end
    sclip = |tclip_r;
    if (acc_x > 43'sd2147483647) begin
      sx    = 32'sh7FFF_FFFF;
      sclip = 1'b1;
    end else if (acc_x < -43'sd2147483648) begin
      sx    = 32'sh8000_0000;
      sclip = 1'b1;
    end else begin
      sx = acc_x[31:0];
    end
    if (acc_y > 43'sd2147483647) begin
      sy    = 32'sh7FFF_FFFF;
      sclip = 1'b1;
    end else if (acc_y < -43'sd2147483648) begin
      sy    = 32'sh8000_0000;
      sclip = 1'b1;
    end else begin
      sy = acc_y[31:0];
    end
  end

  logic signed [31:0] fx_r, fy_r, fx2_r, fy2_r;
  logic               fclip_r, fclip2_r, fv_r, fv2_r;
  logic [31:0]        ax_w, ay_w;
  logic [63:0]        sqx_r, sqy_r;

  assign ax_w = fx_r[31] ? 32'(-fx_r) : fx_r;
  assign ay_w = fy_r[31] ? 32'(-fy_r) : fy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fx_r     <= sx;
      fy_r     <= sy;
      fclip_r  <= sclip;
      sqx_r    <= ax_w * ax_w;
      sqy_r    <= ay_w * ay_w;
      fx2_r    <= fx_r;
      fy2_r    <= fy_r;
      fclip2_r <= fclip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r  <= 1'b0;
      fv2_r <= 1'b0;
    end else if (adv) begin
      fv_r  <= &tv_r;
      fv2_r <= fv_r;
    end
  end

  // Length of the saturated field.
  logic [31:0] len_w;
  logic [64:0] lside;
  logic        lv;

  pce_sqrt #(.IN_W(64), .SIDE_W(65)) u_len (
    .clk, .rst_n, .en(adv), .in_v(fv2_r),
    .rad(sqx_r + sqy_r), .side_in({fx2_r, fy2_r, fclip2_r}),
    .out_v(lv), .root(len_w), .side_out(lside)
  );

  logic signed [31:0] lfx, lfy;
  logic [31:0]        lax, lay;

  assign lfx = lside[64:33];
  assign lfy = lside[32:1];
  assign lax = lfx[31] ? 32'(-lfx) : lfx;
  assign lay = lfy[31] ? 32'(-lfy) : lfy;

  logic [14:0] qx_w, qy_w;
  logic [96:0] dside;
  logic        dyneg;
  logic        dxv, dyv;

  pce_div #(.NUM_W(46), .DEN_W(32), .Q_W(15), .SIDE_W(97)) u_unx (
    .clk, .rst_n, .en(adv), .in_v(lv),
    .num({lax, 14'b0}), .den(len_w), .side_in({lside, len_w}),
    .out_v(dxv), .quo(qx_w), .side_out(dside)
  );

  pce_div #(.NUM_W(46), .DEN_W(32), .Q_W(15), .SIDE_W(1)) u_uny (
    .clk, .rst_n, .en(adv), .in_v(lv),
    .num({lay, 14'b0}), .den(len_w), .side_in(lfy[31]),
    .out_v(dyv), .quo(qy_w), .side_out(dyneg)
  );

  logic signed [31:0] ffx, ffy;
  logic [31:0]        flen;
  logic               fclip;
  logic signed [15:0] ux_w, uy_w;

  always_comb begin
    ffx   = dside[96:65];
    ffy   = dside[64:33];
    fclip = dside[32];
    flen  = dside[31:0];
    ux_w  = '0;
    uy_w  = '0;
    if (flen != 32'd0) begin
      ux_w = ffx[31] ? -$signed({1'b0, qx_w}) : $signed({1'b0, qx_w});
      uy_w = dyneg ? -$signed({1'b0, qy_w}) : $signed({1'b0, qy_w});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      field_x      <= ffx;
      field_y      <= ffy;
      field_length <= flen[31] ? 31'h7FFF_FFFF : flen[30:0];
      unit_x       <= ux_w;
      unit_y       <= uy_w;
      clipped      <= fclip | flen[31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= dxv & dyv;
    end
  end

  assign res_empty = !ov_r;

endmodule

// File: rtl/point_charge_field_evaluator_top.sv
// Top level of the point charge field evaluator.
`timescale 1ns / 1ps
// Evaluates the electric field of up to two configured point charges at one probe point
// per transfer and returns the summed field, its length and its unit direction. A new probe
// is taken every clock cycle while the pipeline advances; the result passes through the
// bit-per-stage square root and divider pipelines (two 32-stage roots, one 52-stage and one
// 15-stage division in series). All stages advance together and halt only while a result
// waits unread, so a stalled reader fills the four-entry input queue and then raises full.
// Charge registers must be written while no probe is in flight.
module point_charge_field_evaluator_top
  import pce_pkg::*;
#(
  parameter int CHARGE_COUNT = CHARGE_COUNT_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_probe_x,
  input  logic [15:0]        in_probe_y,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_field_x,
  output logic signed [31:0] out_field_y,
  output logic [30:0]        out_field_length,
  output logic signed [15:0] out_unit_x,
  output logic signed [15:0] out_unit_y,
  output logic               out_clipped,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [CHARGE_MAX-1:0][15:0] cx_r, cy_r, cq_r;
  logic [15:0]                 radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= {RST_B_X, RST_A_X};
      cy_r     <= {RST_B_Y, RST_A_Y};
      cq_r     <= {RST_B_Q, RST_A_Q};
      radius_r <= RST_RADIUS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_A_X:    cx_r[0]  <= cfg_data;
        REG_A_Y:    cy_r[0]  <= cfg_data;
        REG_A_Q:    cq_r[0]  <= cfg_data;
        REG_B_X:    cx_r[1]  <= cfg_data;
        REG_B_Y:    cy_r[1]  <= cfg_data;
        REG_B_Q:    cq_r[1]  <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data;
        default: ;
      endcase
    end
  end

  chg_t [CHARGE_COUNT-1:0] fe_item, q_item;
  logic                    q_empty, q_pop;

  pce_front #(.CHARGE_COUNT(CHARGE_COUNT)) u_front (
    .probe_x(in_probe_x), .probe_y(in_probe_y),
    .cx(cx_r), .cy(cy_r), .cq(cq_r), .radius(radius_r), .item(fe_item)
  );

  pce_queue #(.W(CHARGE_COUNT * $bits(chg_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(in_push), .wdata(fe_item), .full(in_full),
    .pop(q_pop), .rdata(q_item), .empty(q_empty)
  );

  pce_back #(.CHARGE_COUNT(CHARGE_COUNT)) u_back (
    .clk, .rst_n, .item(q_item), .item_v(!q_empty), .item_pop(q_pop),
    .field_x(out_field_x), .field_y(out_field_y), .field_length(out_field_length),
    .unit_x(out_unit_x), .unit_y(out_unit_y), .clipped(out_clipped),
    .res_empty(out_empty), .res_pop(out_pop)
  );

endmodule

// File: rtl/pce_checker.sv
// Port-level checker for the field evaluator and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [15:0]        in_probe_x,
  input logic [15:0]        in_probe_y,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_field_x,
  input logic signed [31:0] out_field_y,
  input logic [30:0]        out_field_length,
  input logic signed [15:0] out_unit_x,
  input logic signed [15:0] out_unit_y,
  input logic               out_clipped,
  input logic               cfg_we,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data
);

  // A direction component never exceeds one in magnitude.
  `ASSERT_OUT(a_unit_x_range, (out_unit_x <= 16'sd16384) && (out_unit_x >= -16'sd16384), "unit_x out of range")
  `ASSERT_OUT(a_unit_y_range, (out_unit_y <= 16'sd16384) && (out_unit_y >= -16'sd16384), "unit_y out of range")

  // A field of zero length has no direction.
  `ASSERT_OUT(a_zero_dir, (out_field_length != 31'd0) || ((out_unit_x == 16'sd0) && (out_unit_y == 16'sd0)), "direction set on zero field")

  // A result that is not taken stays on the ports with its x field, length and clip flag unchanged.
  `ASSERT_CLK(a_hold, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_field_x) && $stable(out_field_length) && $stable(out_clipped)), "waiting result changed")

endmodule

bind point_charge_field_evaluator_top pce_checker u_pce_checker (.*);

// File: tb/tb.sv
// Self-checking testbench for the point charge field evaluator top level.
`timescale 1ns / 1ps
module tb;
  import pce_pkg::*;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
  } probe_t;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic [30:0]        len;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic               clip;
  } field_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [15:0]        in_probe_x = '0;
  logic [15:0]        in_probe_y = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_field_x;
  logic signed [31:0] out_field_y;
  logic [30:0]        out_field_length;
  logic signed [15:0] out_unit_x;
  logic signed [15:0] out_unit_y;
  logic               out_clipped;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  probe_t      probe_q[$];
  field_t      field_exp_q[$];
  logic [15:0] charge_reg[7];
  int          send_gap = 0;
  int          pop_stall = 0;
  int          pop_hold = 0;
  bit          calm = 1'b0;
  int          mismatches = 0;

  point_charge_field_evaluator_top i_dut (.*);

  always #6 clk = ~clk;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic field_t field_at(logic [15:0] px, logic [15:0] py);
    field_t      res;
    logic [63:0] r2, ad[2], d2, s, aq, m, u, t, ax, ay, len, ux, uy;
    logic [127:0] prod;
    longint      acc[2];
    longint      fx, fy;
    int          dd[2];
    int          qv;
    int          base;
    bit          clip;
    bit          neg;
    r2 = 64'(charge_reg[REG_RADIUS]) * 64'(charge_reg[REG_RADIUS]);
    acc[0] = 0;
    acc[1] = 0;
    clip = 1'b0;
    for (int k = 0; k < 2; k++) begin
      base = (k == 0) ? int'(REG_A_X) : int'(REG_B_X);
      dd[0] = int'(px) - int'(charge_reg[base]);
      dd[1] = int'(py) - int'(charge_reg[base + 1]);
      qv = int'($signed(charge_reg[base + 2]));
      for (int c = 0; c < 2; c++) ad[c] = 64'((dd[c] < 0) ? -dd[c] : dd[c]);
      d2 = ad[0] * ad[0] + ad[1] * ad[1];
      if (d2 == 0 || d2 < r2) continue;
      s = root_floor(d2 << 30);
      aq = 64'((qv < 0) ? -qv : qv);
      m = (aq << 36) / d2;
      for (int c = 0; c < 2; c++) begin
        u = (ad[c] << 45) / s;
        prod = {64'd0, m} * {64'd0, u};
        t = prod[93:30];
        neg = (qv < 0) != (dd[c] < 0);
        if (t > 64'd1 << 40) begin
          t = 64'd1 << 40;
          clip = 1'b1;
        end
        acc[c] += neg ? -longint'(t) : longint'(t);
      end
    end
    fx = acc[0];
    fy = acc[1];
    if (fx > 64'sd2147483647) begin fx = 64'sd2147483647; clip = 1'b1; end
    if (fx < -64'sd2147483648) begin fx = -64'sd2147483648; clip = 1'b1; end
    if (fy > 64'sd2147483647) begin fy = 64'sd2147483647; clip = 1'b1; end
    if (fy < -64'sd2147483648) begin fy = -64'sd2147483648; clip = 1'b1; end
    ax = 64'((fx < 0) ? -fx : fx);
    ay = 64'((fy < 0) ? -fy : fy);
    len = root_floor(ax * ax + ay * ay);
    ux = '0;
    uy = '0;
    if (len != 0) begin
      ux = (ax << 14) / len;
      uy = (ay << 14) / len;
    end
    res.fx = fx[31:0];
    res.fy = fy[31:0];
    if (len > 64'h7FFF_FFFF) begin
      res.len = 31'h7FFF_FFFF;
      clip = 1'b1;
    end else begin
      res.len = len[30:0];
    end
    res.ux = (fx < 0) ? -ux[15:0] : ux[15:0];
    res.uy = (fy < 0) ? -uy[15:0] : uy[15:0];
    res.clip = clip;
    return res;
  endfunction

  // Mostly short idle gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: inputs change on the falling edge.
  always @(negedge clk) begin
    if (!rst_n || probe_q.size() == 0) begin
      in_push <= 1'b0;
    end else if (send_gap > 0) begin
      send_gap--;
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_probe_x <= probe_q[0].px;
      in_probe_y <= probe_q[0].py;
    end
  end

  // Receiver side with random stalls and a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      out_pop <= 1'b0;
    end else if (pop_stall > 0) begin
      pop_stall--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
      pop_stall = idle_len();
    end
  end

  // Monitor: both handshakes are sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      field_exp_q.push_back(field_at(in_probe_x, in_probe_y));
      void'(probe_q.pop_front());
      send_gap = idle_len();
    end
    if (rst_n && out_pop && !out_empty) begin
      if (field_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        field_t e;
        e = field_exp_q.pop_front();
        if (out_field_x !== e.fx || out_field_y !== e.fy || out_field_length !== e.len ||
            out_unit_x !== e.ux || out_unit_y !== e.uy || out_clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp %0d %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0d %0b",
                     $realtime, e.fx, e.fy, e.len, e.ux, e.uy, e.clip, out_field_x,
                     out_field_y, out_field_length, out_unit_x, out_unit_y, out_clipped);
        end
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    charge_reg[idx] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_probe(logic [15:0] x, logic [15:0] y);
    probe_t p;
    p.px = x;
    p.py = y;
    probe_q.push_back(p);
  endtask

  task automatic wait_idle();
    while (probe_q.size() != 0 || field_exp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_charge();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    if (r < 6) return 16'($urandom_range(0, 4095)) - 16'd2048;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_radius();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r < 6) return 16'($urandom_range(0, 2000));
    return 16'($urandom_range(0, 20000));
  endfunction

  // Half the probes cluster around the charges so that exclusion and large terms occur often.
  task automatic add_random_probe();
    int r;
    int base;
    int span;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      add_probe(16'($urandom), 16'($urandom));
    end else begin
      base = (r < 7) ? int'(REG_A_X) : int'(REG_B_X);
      span = (r == 9) ? 4 : 1500;
      add_probe(16'(int'(charge_reg[base]) + $urandom_range(0, 2 * span) - span),
                16'(int'(charge_reg[base + 1]) + $urandom_range(0, 2 * span) - span));
    end
  endtask

  initial begin
    charge_reg[REG_A_X] = RST_A_X;
    charge_reg[REG_A_Y] = RST_A_Y;
    charge_reg[REG_A_Q] = RST_A_Q;
    charge_reg[REG_B_X] = RST_B_X;
    charge_reg[REG_B_Y] = RST_B_Y;
    charge_reg[REG_B_Q] = RST_B_Q;
    charge_reg[REG_RADIUS] = RST_RADIUS;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings: corners, charge A's center, inside exclusion.
    add_probe(16'd0, 16'd0);
    add_probe(16'hFFFF, 16'hFFFF);
    add_probe(16'd0, 16'hFFFF);
    add_probe(16'hFFFF, 16'd0);
    add_probe(RST_A_X, RST_A_Y);
    add_probe(RST_B_X + 16'd100, RST_B_Y - 16'd100);
    add_probe(RST_A_X + 16'd700, RST_A_Y);
    add_probe(16'h5555, 16'hAAAA);
    add_probe(16'hAAAA, 16'h5555);
    wait_idle();

    // Strongest charges at the same point with no exclusion: capped terms and saturation.
    write_reg(REG_A_Q, 16'h7FFF);
    write_reg(REG_B_Q, 16'h7FFF);
    write_reg(REG_RADIUS, 16'd0);
    write_reg(REG_A_X, 16'd1000);
    write_reg(REG_A_Y, 16'd1000);
    write_reg(REG_B_X, 16'd1000);
    write_reg(REG_B_Y, 16'd1000);
    add_probe(16'd1001, 16'd1001);
    add_probe(16'd999, 16'd1000);
    add_probe(16'd1000, 16'd1000);
    add_probe(16'd1000, 16'd1003);
    wait_idle();
    write_reg(REG_B_Q, 16'h8000);
    write_reg(REG_B_X, 16'd1002);
    add_probe(16'd1001, 16'd1000);
    add_probe(16'd1001, 16'd1001);
    add_probe(16'd0, 16'd0);
    wait_idle();
    // Largest radius: the near probe is excluded, the far corner still sees a field.
    write_reg(REG_RADIUS, 16'hFFFF);
    add_probe(16'hFFFF, 16'hFFFF);
    add_probe(16'd1001, 16'd1001);
    wait_idle();

    // Random phases with fresh settings; one phase holds the reader off for a long time.
    for (int ph = 0; ph < 9; ph++) begin
      calm = (ph == 3);
      for (int i = 0; i < 7; i++) begin
        if (ph == 0 || $urandom_range(0, 2) == 0) begin
          if (i == int'(REG_A_Q) || i == int'(REG_B_Q)) write_reg(cfg_reg_t'(i), pick_charge());
          else if (i == int'(REG_RADIUS)) write_reg(cfg_reg_t'(i), pick_radius());
          else write_reg(cfg_reg_t'(i), pick_pos());
        end
      end
      for (int n = 0; n < 137; n++) add_random_probe();
      if (ph == 5) pop_hold = 400;
      wait_idle();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && field_exp_q.size() == 0) begin
      $display("point_charge_field_evaluator_top regression: pass");
    end else begin
      $display("point_charge_field_evaluator_top regression: fail");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("point_charge_field_evaluator_top regression: fail");
    $finish;
  end

endmodule
